// File: rtl/dbd_pkg.sv
// Shared types and constants for the date difference block.
// Used by dbd_ctrl, dbd_dp and days_between_dates; depends on nothing.
package dbd_pkg;

    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 12;
    localparam int OrdW   = 21;
    localparam int StartW = 9;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    localparam logic [8:0] DaysPerYear = 9'd365;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ORD_A,
        S_ORD_B,
        S_DIFF
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_a;
        logic calc_b;
        logic load_out;
    } t_dp_cmd;

    // Days in all months before the given month (1..12) of a common year.
    function automatic logic [StartW-1:0] month_start(input logic [MonthW-1:0] month);
        logic [StartW-1:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// File: rtl/days_between_dates.sv
// Top level of the date difference block: controller plus datapath.
// Depends on dbd_pkg, dbd_ctrl and dbd_dp.
//
// Takes a word holding two calendar dates and returns one word with the day count
// from the first date to the second. Every year divisible by four, year 0 included,
// is a leap year; there is no century rule. Months below 1 count as January, above 12
// as December, years above MAX_YEAR as MAX_YEAR, and the day is counted at face value.
// When the second date precedes the first, the result is 0 with order_error set.
// Each date is turned into a day ordinal by one shared ordinal unit (one 12x9 multiply
// and a few adds), one date per cycle, and the two ordinals are then compared and
// subtracted. A word is held in S_IDLE, its ordinals are registered in S_ORD_A and
// S_ORD_B, and S_DIFF loads the result once the output is free; no new word enters before.
// The input side is free again as soon as a result is loaded into the output
// register, so a result waiting on i_ready does not stop the next word from entering.
module days_between_dates #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dbd_pkg::DayW-1:0]    i_first_day,
    input  logic [dbd_pkg::MonthW-1:0]  i_first_month,
    input  logic [dbd_pkg::YearW-1:0]   i_first_year,
    input  logic [dbd_pkg::DayW-1:0]    i_second_day,
    input  logic [dbd_pkg::MonthW-1:0]  i_second_month,
    input  logic [dbd_pkg::YearW-1:0]   i_second_year,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dbd_pkg::OrdW-1:0]    o_day_difference,
    output logic                        o_order_error
);
    import dbd_pkg::*;

    t_dp_cmd cmd;

    // Sequence each word: hold inputs, ordinal of A, ordinal of B, difference.
    dbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    dbd_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_first_day      (i_first_day),
        .i_first_month    (i_first_month),
        .i_first_year     (i_first_year),
        .i_second_day     (i_second_day),
        .i_second_month   (i_second_month),
        .i_second_year    (i_second_year),
        .o_day_difference (o_day_difference),
        .o_order_error    (o_order_error)
    );

    // A flagged result always carries a zero count.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_order_error) |-> (o_day_difference == '0))
        else $error("order error with nonzero day count");

    // Once a word is taken, input ready drops until the word has been worked.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready while a word is in work");

    // A taken result with nothing new behind it clears the output.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !cmd.load_out) |=> !o_valid)
        else $error("output valid held after the result was taken");

endmodule

// File: rtl/dbd_ctrl.sv
// Controller for the date difference block: sequences one word through the datapath.
// Depends on dbd_pkg.
module dbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output dbd_pkg::t_dp_cmd o_cmd
);
    import dbd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_ORD_A;
            S_ORD_A: n_state = S_ORD_B;
            S_ORD_B: n_state = S_DIFF;
            S_DIFF:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            S_ORD_A: o_cmd.calc_a = 1'b1;
            S_ORD_B: o_cmd.calc_b = 1'b1;
            S_DIFF:  o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/dbd_dp.sv
// Datapath for the date difference block: input hold, shared ordinal unit, result register.
// Depends on dbd_pkg.
module dbd_dp #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                         i_clk,
    input  dbd_pkg::t_dp_cmd             i_cmd,
    input  logic [dbd_pkg::DayW-1:0]     i_first_day,
    input  logic [dbd_pkg::MonthW-1:0]   i_first_month,
    input  logic [dbd_pkg::YearW-1:0]    i_first_year,
    input  logic [dbd_pkg::DayW-1:0]     i_second_day,
    input  logic [dbd_pkg::MonthW-1:0]   i_second_month,
    input  logic [dbd_pkg::YearW-1:0]    i_second_year,
    output logic [dbd_pkg::OrdW-1:0]     o_day_difference,
    output logic                         o_order_error
);
    import dbd_pkg::*;

    localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

    logic [DayW-1:0]   r_day_a, r_day_b;
    logic [MonthW-1:0] r_month_a, r_month_b;
    logic [YearW-1:0]  r_year_a, r_year_b;
    logic [OrdW-1:0]   r_ord_a, r_ord_b;
    logic [OrdW-1:0]   r_day_difference;
    logic              r_order_error;

    logic [DayW-1:0]   sel_day;
    logic [MonthW-1:0] sel_month, month_c;
    logic [YearW-1:0]  sel_year, year_c;
    logic [YearW:0]    year_rnd;
    logic [OrdW-1:0]   ordinal;
    logic [OrdW-1:0]   diff;
    logic              reversed;

    // Shared ordinal unit: B date during calc_b, A date otherwise.
    always_comb begin
        sel_day   = i_cmd.calc_b ? r_day_b   : r_day_a;
        sel_month = i_cmd.calc_b ? r_month_b : r_month_a;
        sel_year  = i_cmd.calc_b ? r_year_b  : r_year_a;

        month_c = sel_month;
        if (sel_month < MonthJan) month_c = MonthJan;
        if (sel_month > MonthDec) month_c = MonthDec;

        year_c = sel_year;
        if (17'(sel_year) > MaxYearW) year_c = MaxYearW[YearW-1:0];

        year_rnd = {1'b0, year_c} + (YearW+1)'(3);
        ordinal  = OrdW'(year_c) * OrdW'(DaysPerYear)
                 + OrdW'(year_rnd >> 2)
                 + OrdW'(month_start(month_c))
                 + OrdW'(sel_day);
        if (year_c[1:0] == 2'b00 && month_c > MonthFeb) begin
            ordinal = ordinal + OrdW'(1);
        end
    end

    assign reversed = r_ord_b < r_ord_a;
    assign diff     = r_ord_b - r_ord_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_day_a   <= i_first_day;
            r_month_a <= i_first_month;
            r_year_a  <= i_first_year;
            r_day_b   <= i_second_day;
            r_month_b <= i_second_month;
            r_year_b  <= i_second_year;
        end
        if (i_cmd.calc_a) r_ord_a <= ordinal;
        if (i_cmd.calc_b) r_ord_b <= ordinal;
        if (i_cmd.load_out) begin
            r_day_difference <= reversed ? '0 : diff;
            r_order_error    <= reversed;
        end
    end

    assign o_day_difference = r_day_difference;
    assign o_order_error    = r_order_error;

endmodule
